FILE: design/assert_macros.svh
// assertion macros shared by the scanner rtl
// expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define WSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies consequence in the next cycle
`define WSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/wsc_pkg.sv
// shared types and constants for the wildcard byte signature scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsc_pkg;

    localparam int MAX_PATTERN_DEF   = 24;
    localparam int INDEX_WIDTH_DEF   = 32;
    localparam int PATTERN_REG_BYTES = 24;
    localparam int DISP_BYTES        = 4;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int ADJ_W             = 6;

    localparam logic [ADJ_W-1:0] REL_ADJ = 6'd7;
    localparam logic [ADJ_W-1:0] JMP_ADJ = 6'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_MID  = 3'd1,
        REG_PATTERN_HIGH = 3'd2,
        REG_WILDCARD     = 3'd3,
        REG_LENGTH       = 3'd4,
        REG_MODE         = 3'd5,
        REG_OFFSET       = 3'd6,
        REG_BASE         = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_PLAIN    = 2'd0,
        MODE_ABSOLUTE = 2'd1,
        MODE_RELATIVE = 2'd2,
        MODE_JUMP     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [63:0]      start;
        logic [31:0]      disp;
        logic [ADJ_W-1:0] adj;
        logic             first;
    } hit_t;

endpackage

`default_nettype wire

FILE: design/wsc_cell.sv
// one window cell: holds a byte and its valid bit, compares the incoming byte
// uses no package
`timescale 1ns / 1ps
`default_nettype none

module wsc_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic       clear,
    input  wire logic [7:0] d_in,
    input  wire logic       v_in,
    input  wire logic [7:0] expected,
    input  wire logic       care,
    input  wire logic       used,
    output logic      [7:0] q,
    output logic            q_valid,
    output logic            ok
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        byte_next  = shift ? d_in : byte_reg;
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // compare against the byte this cell takes on the shift
    assign ok      = !used || (v_in && (!care || (d_in == expected)));
    assign q       = byte_reg;
    assign q_valid = valid_reg;

endmodule

`default_nettype wire

FILE: design/wsc_resolve.sv
// two-stage address resolver with output register for the scanner
// depends on wsc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wsc_resolve (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hit_valid,
    output logic               hit_ready,
    input  wire wsc_pkg::hit_t hit,
    input  wire logic [63:0]   image_base,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic      [31:0]   match_index,
    output logic      [63:0]   resolved_address,
    output logic               is_first_match
);

    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic [63:0] s2_a_reg;
    logic [63:0] s2_b_reg;
    logic [31:0] s2_index_reg;
    logic        s2_first_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_addr_reg;
    logic [31:0] out_index_reg;
    logic        out_first_reg;
    logic        out_free;
    logic        s2_free;
    logic        s2_move;

    assign out_free  = !out_valid_reg || out_ready;
    assign s2_move   = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign hit_ready = s2_free;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_free)
        begin
            s2_valid_next = hit_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_valid && s2_free)
        begin
            s2_a_reg     <= image_base + hit.start;
            s2_b_reg     <= {{32{hit.disp[31]}}, hit.disp} + {58'd0, hit.adj};
            s2_index_reg <= hit.start[31:0];
            s2_first_reg <= hit.first;
        end
        if (s2_move)
        begin
            out_addr_reg  <= s2_a_reg + s2_b_reg;
            out_index_reg <= s2_index_reg;
            out_first_reg <= s2_first_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign match_index      = out_index_reg;
    assign resolved_address = out_addr_reg;
    assign is_first_match   = out_first_reg;

    `WSC_ASSERT_NEXT(a_s2_to_out, s2_valid_reg && out_free, out_valid_reg, "resolved word lost")
    `WSC_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !out_free, s2_valid_reg && $stable(s2_a_reg), "stalled word changed")

endmodule

`default_nettype wire

FILE: design/wildcard_byte_signature_scanner.sv
// Scans an image one byte per cycle, unless the output stalls it, through a
// row of MAX_PATTERN window cells and reports every masked pattern match with
// its index and resolved address. A new byte is taken every cycle in which
// in_valid and in_ready are both high; a match passes through the hit register
// and the two-stage 64-bit address adder to the outputs. Backpressure from the
// output only stops input once the hit register and both resolver stages are
// full. No clearing pass after reset.
// depends on wsc_pkg, wsc_cell, wsc_resolve and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wildcard_byte_signature_scanner #(
    parameter int MAX_PATTERN = wsc_pkg::MAX_PATTERN_DEF,
    parameter int INDEX_WIDTH = wsc_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [wsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           last_in_image,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [31:0]                    match_index,
    output logic      [63:0]                    resolved_address,
    output logic                                is_first_match
);

    localparam int SW = ($clog2(MAX_PATTERN + 1) > 6) ? $clog2(MAX_PATTERN + 1) : 6;
    localparam int WB = MAX_PATTERN * 8;
    localparam logic [SW-1:0] MAX_SPAN  = SW'(MAX_PATTERN);
    localparam logic [SW-1:0] REG_BYTES = SW'(wsc_pkg::PATTERN_REG_BYTES);

    // configuration
    logic [63:0]          pattern_low_reg;
    logic [63:0]          pattern_mid_reg;
    logic [63:0]          pattern_high_reg;
    logic [23:0]          wildcard_reg;
    logic [4:0]           length_reg;
    wsc_pkg::mode_t       mode_reg;
    logic [4:0]           offset_reg;
    logic [63:0]          base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_mid_reg  <= '0;
            pattern_high_reg <= '0;
            wildcard_reg     <= '0;
            length_reg       <= 5'd1;
            mode_reg         <= wsc_pkg::MODE_PLAIN;
            offset_reg       <= '0;
            base_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (wsc_pkg::cfg_index_t'(cfg_index))
                wsc_pkg::REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                wsc_pkg::REG_PATTERN_MID:  pattern_mid_reg  <= cfg_data;
                wsc_pkg::REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                wsc_pkg::REG_WILDCARD:     wildcard_reg     <= cfg_data[23:0];
                wsc_pkg::REG_LENGTH:       length_reg       <= cfg_data[4:0];
                wsc_pkg::REG_MODE:         mode_reg         <= wsc_pkg::mode_t'(cfg_data[1:0]);
                wsc_pkg::REG_OFFSET:       offset_reg       <= cfg_data[4:0];
                wsc_pkg::REG_BASE:         base_reg         <= cfg_data;
                default:                   base_reg         <= base_reg;
            endcase
        end
    end

    // effective length and span
    logic [SW-1:0] len;
    logic [SW-1:0] fo_ext;
    logic [SW-1:0] fo_span;
    logic [SW-1:0] span;
    logic          span_ok;

    assign fo_ext  = {{(SW-5){1'b0}}, offset_reg};
    assign fo_span = fo_ext + SW'(wsc_pkg::DISP_BYTES);

    always_comb
    begin
        len = {{(SW-5){1'b0}}, length_reg};
        if (len == '0)
        begin
            len = SW'(1);
        end
        if (len > REG_BYTES)
        begin
            len = REG_BYTES;
        end
        if (len > MAX_SPAN)
        begin
            len = MAX_SPAN;
        end
        span = len;
        if (mode_reg != wsc_pkg::MODE_PLAIN && fo_span > len)
        begin
            span = fo_span;
        end
    end

    assign span_ok = (span <= MAX_SPAN);

    // pattern reversed and aligned so that cell i sees pattern byte span-1-i
    logic [191:0]          pat24;
    logic [WB-1:0]         rev_pat;
    logic [MAX_PATTERN-1:0] rev_care;
    logic [SW-1:0]         align;
    logic [WB-1:0]         exp_vec;
    logic [MAX_PATTERN-1:0] care_vec;

    assign pat24 = {pattern_high_reg, pattern_mid_reg, pattern_low_reg};
    assign align = MAX_SPAN - span;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_pat
        if (k < wsc_pkg::PATTERN_REG_BYTES)
        begin : g_real
            assign rev_pat[8*(MAX_PATTERN-1-k) +: 8] = pat24[8*k +: 8];
            assign rev_care[MAX_PATTERN-1-k]          = !wildcard_reg[k] && (SW'(k) < len);
        end
        else
        begin : g_none
            assign rev_pat[8*(MAX_PATTERN-1-k) +: 8] = 8'd0;
            assign rev_care[MAX_PATTERN-1-k]          = 1'b0;
        end
    end

    assign exp_vec  = rev_pat >> {align, 3'b000};
    assign care_vec = rev_care >> align;

    // cell row
    logic                    in_accept;
    logic [WB-1:0]           din_vec;
    logic [MAX_PATTERN-1:0]  vin_vec;
    logic [WB-1:0]           q_vec;
    logic [MAX_PATTERN-1:0]  qv_vec;
    logic [MAX_PATTERN-1:0]  ok_vec;

    assign din_vec = {q_vec[WB-9:0], data_byte};
    assign vin_vec = {qv_vec[MAX_PATTERN-2:0], 1'b1};

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        wsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (in_accept),
            .clear    (in_accept && last_in_image),
            .d_in     (din_vec[8*i +: 8]),
            .v_in     (vin_vec[i]),
            .expected (exp_vec[8*i +: 8]),
            .care     (care_vec[i]),
            .used     (SW'(i) < span),
            .q        (q_vec[8*i +: 8]),
            .q_valid  (qv_vec[i]),
            .ok       (ok_vec[i])
        );
    end

    // displacement bytes and address adjust
    logic [SW-1:0]                disp_pos;
    logic [WB-1:0]                disp_win;
    logic [31:0]                  disp;
    logic [wsc_pkg::ADJ_W-1:0]    adj;

    assign disp_pos = span - fo_span;
    assign disp_win = din_vec >> {disp_pos, 3'b000};

    always_comb
    begin
        disp = {disp_win[7:0], disp_win[15:8], disp_win[23:16], disp_win[31:24]};
        adj  = {1'b0, offset_reg};
        case (mode_reg)
            wsc_pkg::MODE_PLAIN:
            begin
                disp = '0;
            end
            wsc_pkg::MODE_ABSOLUTE:
            begin
                adj = {1'b0, offset_reg} + wsc_pkg::ADJ_W'(wsc_pkg::DISP_BYTES);
            end
            wsc_pkg::MODE_RELATIVE:
            begin
                adj = wsc_pkg::REL_ADJ;
            end
            wsc_pkg::MODE_JUMP:
            begin
                adj = wsc_pkg::JMP_ADJ;
            end
            default:
            begin
                disp = '0;
            end
        endcase
    end

    // match, index and first flag
    logic                   hit;
    logic [INDEX_WIDTH-1:0] count_reg;
    logic [INDEX_WIDTH-1:0] count_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic [INDEX_WIDTH-1:0] start;
    logic [SW-1:0]          span_m1;

    assign hit     = span_ok && (&ok_vec);
    assign span_m1 = span - SW'(1);
    assign start   = count_reg - INDEX_WIDTH'(span_m1);

    always_comb
    begin
        count_next = count_reg;
        seen_next  = seen_reg;
        if (in_accept)
        begin
            if (last_in_image)
            begin
                count_next = '0;
                seen_next  = 1'b0;
            end
            else
            begin
                count_next = count_reg + INDEX_WIDTH'(1);
                seen_next  = seen_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    // hit register
    logic          s1_valid_reg;
    logic          s1_valid_next;
    wsc_pkg::hit_t s1_reg;
    logic          rs_ready;

    assign in_ready  = !s1_valid_reg || rs_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = hit;
        end
        else if (rs_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && hit)
        begin
            s1_reg.start <= {{(64-INDEX_WIDTH){1'b0}}, start};
            s1_reg.disp  <= disp;
            s1_reg.adj   <= adj;
            s1_reg.first <= !seen_reg;
        end
    end

    wsc_resolve u_resolve (
        .clk              (clk),
        .rst_n            (rst_n),
        .hit_valid        (s1_valid_reg),
        .hit_ready        (rs_ready),
        .hit              (s1_reg),
        .image_base       (base_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .match_index      (match_index),
        .resolved_address (resolved_address),
        .is_first_match   (is_first_match)
    );

    `WSC_ASSERT_NEXT(a_hit_held, in_accept && hit, s1_valid_reg, "match word dropped")
    `WSC_ASSERT_NEXT(a_end_clear, in_accept && last_in_image,
                     count_reg == '0 && !seen_reg && qv_vec == '0,
                     "image end did not clear state")
    `WSC_ASSERT_NEXT(a_seen_set, in_accept && hit && !last_in_image, seen_reg,
                     "first match flag not recorded")
    `WSC_ASSERT(a_cell_fill, ($countones(qv_vec) == 0) || qv_vec[0],
                "window valid bits not contiguous")

endmodule

`default_nettype wire

FILE: sim/wildcard_byte_signature_scanner_test.sv
// self-checking testbench for wildcard_byte_signature_scanner: a directed table, then random
// images with planted patterns, every match checked against an in-bench scan model
// depends on wsc_pkg and the scanner rtl
`timescale 1ns / 1ps

module wildcard_byte_signature_scanner_test;

    localparam int MAXP           = wsc_pkg::MAX_PATTERN_DEF;
    localparam int DISP_N         = wsc_pkg::DISP_BYTES;
    localparam int DIRECTED_ROWS  = 48;
    localparam int RANDOM_ITEMS   = 450;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] index;
        logic [63:0] addr;
        logic        first;
    } match_t;

    typedef struct packed {
        bit                  is_cfg;
        wsc_pkg::cfg_index_t idx;
        logic [63:0]         val;
        logic [7:0]          b;
        logic                fin;
        bit                  typed;
        bit                  t_has;
        match_t              t_m;
    } step_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [wsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]                     cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      data_byte;
    logic                            last_in_image;
    logic                            out_valid;
    logic                            out_ready;
    logic [31:0]                     match_index;
    logic [63:0]                     resolved_address;
    logic                            is_first_match;

    // scan model state
    logic [63:0]    pat_lo   = '0;
    logic [63:0]    pat_mid  = '0;
    logic [63:0]    pat_hi   = '0;
    logic [23:0]    wc_mask  = '0;
    logic [4:0]     len_reg  = 5'd1;
    wsc_pkg::mode_t mode_reg = wsc_pkg::MODE_PLAIN;
    logic [4:0]     off_reg  = '0;
    logic [63:0]    base_reg = '0;
    logic [7:0]     window [MAXP] = '{default: '0};
    logic [31:0]    byte_count = '0;
    bit             seen_match = 0;
    int             fill = 0;

    match_t expected_matches [$];
    int     mismatches = 0;
    int     quiet_cycles = 0;
    int     burst_left = 0;
    bit     bursty = 1;
    step_t  plan [DIRECTED_ROWS];

    wildcard_byte_signature_scanner DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_len();
        int n;
        n = (len_reg == 0) ? 1 : int'(len_reg);
        if (n > wsc_pkg::PATTERN_REG_BYTES)
            n = wsc_pkg::PATTERN_REG_BYTES;
        if (n > MAXP)
            n = MAXP;
        return n;
    endfunction

    function automatic int eff_span();
        int s;
        s = eff_len();
        if (mode_reg != wsc_pkg::MODE_PLAIN && int'(off_reg) + DISP_N > s)
            s = int'(off_reg) + DISP_N;
        return s;
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic fin, output match_t m);
        int          n_len;
        int          span_len;
        bit          hit;
        logic [31:0] st;
        logic [31:0] raw;
        logic [63:0] disp;
        logic [63:0] p;
        logic [191:0] pats;
        pats = {pat_hi, pat_mid, pat_lo};
        m = '0;
        for (int k = MAXP - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = b;
        if (fill < MAXP)
            fill++;
        n_len = eff_len();
        span_len = eff_span();
        hit = 0;
        if (span_len <= MAXP && fill >= span_len)
        begin
            hit = 1;
            for (int j = 0; j < n_len; j++)
                if (!wc_mask[j] && window[span_len - 1 - j] != pats[8 * j +: 8])
                    hit = 0;
        end
        if (hit)
        begin
            st = byte_count - 32'(span_len - 1);
            p = base_reg + {32'b0, st};
            if (mode_reg == wsc_pkg::MODE_PLAIN)
                m.addr = p + 64'(off_reg);
            else
            begin
                for (int j = 0; j < DISP_N; j++)
                    raw[8 * j +: 8] = window[span_len - 1 - (int'(off_reg) + j)];
                disp = {{32{raw[31]}}, raw};
                case (mode_reg)
                    wsc_pkg::MODE_ABSOLUTE:
                        m.addr = p + 64'(off_reg) + 64'(DISP_N) + disp;
                    wsc_pkg::MODE_RELATIVE:
                        m.addr = p + 64'(wsc_pkg::REL_ADJ) + disp;
                    default:
                        m.addr = p + 64'(wsc_pkg::JMP_ADJ) + disp;
                endcase
            end
            m.index = st;
            m.first = !seen_match;
            seen_match = 1;
        end
        byte_count++;
        if (fin)
        begin
            window = '{default: '0};
            byte_count = '0;
            seen_match = 0;
            fill = 0;
        end
        return hit;
    endfunction

    function automatic step_t cfg_row(input wsc_pkg::cfg_index_t idx, input logic [63:0] v);
        step_t r = '0;
        r.is_cfg = 1;
        r.idx = idx;
        r.val = v;
        return r;
    endfunction

    function automatic step_t byte_row(input logic [7:0] b, input logic fin);
        step_t r = '0;
        r.b = b;
        r.fin = fin;
        return r;
    endfunction

    function automatic step_t none_row(input logic [7:0] b, input logic fin);
        step_t r;
        r = byte_row(b, fin);
        r.typed = 1;
        return r;
    endfunction

    function automatic step_t hit_row(input logic [7:0] b, input logic fin,
                                      input logic [31:0] idx, input logic [63:0] addr,
                                      input logic first);
        step_t r;
        r = none_row(b, fin);
        r.t_has = 1;
        r.t_m = '{index: idx, addr: addr, first: first};
        return r;
    endfunction

    function automatic logic [63:0] pad_upper(input logic [63:0] v, input int w);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return ($urandom_range(0, 1) == 0) ? v : (v | (junk << w));
    endfunction

    task automatic write_reg(input wsc_pkg::cfg_index_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            wsc_pkg::REG_PATTERN_LOW:  pat_lo   = val;
            wsc_pkg::REG_PATTERN_MID:  pat_mid  = val;
            wsc_pkg::REG_PATTERN_HIGH: pat_hi   = val;
            wsc_pkg::REG_WILDCARD:     wc_mask  = val[23:0];
            wsc_pkg::REG_LENGTH:       len_reg  = val[4:0];
            wsc_pkg::REG_MODE:         mode_reg = wsc_pkg::mode_t'(val[1:0]);
            wsc_pkg::REG_OFFSET:       off_reg  = val[4:0];
            wsc_pkg::REG_BASE:         base_reg = val;
            default:                   base_reg = base_reg;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input bit t_has, input match_t t_m);
        match_t m;
        bit     has;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (bursty)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        data_byte     <= b;
        last_in_image <= fin;
        do @(posedge clk); while (!in_ready);
        has = scan_byte(b, fin, m);
        if (typed)
        begin
            has = t_has;
            m = t_m;
        end
        if (has)
            expected_matches = {expected_matches, m};
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void flag_mismatch(input bit orphan, input match_t want, input match_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (orphan)
                $display("unexpected word: index %0d addr %h first %0b",
                         got.index, got.addr, got.first);
            else
                $display({"mismatch: expected index %0d addr %h first %0b, ",
                          "got index %0d addr %h first %0b"},
                         want.index, want.addr, want.first, got.index, got.addr, got.first);
        end
    endfunction

    // output check and watchdog activity
    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{index: match_index, addr: resolved_address, first: is_first_match};
            if (expected_matches.size() == 0)
                flag_mismatch(1, '0, got);
            else
            begin
                want = expected_matches.pop_front();
                if (got !== want)
                    flag_mismatch(0, want, got);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls
    initial
    begin
        logic [15:0] ready_bits;
        int          hold;
        int          pos;
        ready_bits = '1;
        hold = 0;
        pos = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                hold = $urandom_range(16, 64);
                ready_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
            end
            hold--;
            out_ready <= ready_bits[pos];
            pos = (pos + 1) % 16;
        end
    end

    initial
    begin
        bit          busy;
        int          random_sent;
        int          n;
        int          phase_len;
        int          span_len;
        int          n_len;
        int          k;
        logic [63:0] v;
        logic [191:0] pats;
        logic [7:0]  chunk [$];

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = wsc_pkg::REG_PATTERN_LOW;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        last_in_image = 1'b0;

        plan = '{
            // reset settings: one zero byte pattern, plain mode
            hit_row(8'h00, 0, 0, 64'd0, 1),
            none_row(8'hFF, 0),
            hit_row(8'h00, 1, 2, 64'd2, 0),
            // zero length acts as one, base wraps
            cfg_row(wsc_pkg::REG_PATTERN_LOW, 64'hAB),
            cfg_row(wsc_pkg::REG_LENGTH, 64'd0),
            cfg_row(wsc_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(wsc_pkg::REG_OFFSET, 64'd3),
            hit_row(8'hAB, 0, 0, 64'd2, 1),
            hit_row(8'hAB, 1, 1, 64'd3, 0),
            // absolute with most negative displacement
            cfg_row(wsc_pkg::REG_MODE, 64'(wsc_pkg::MODE_ABSOLUTE)),
            cfg_row(wsc_pkg::REG_LENGTH, 64'd2),
            cfg_row(wsc_pkg::REG_PATTERN_LOW, 64'h0FE8),
            cfg_row(wsc_pkg::REG_WILDCARD, 64'd0),
            cfg_row(wsc_pkg::REG_OFFSET, 64'd2),
            cfg_row(wsc_pkg::REG_BASE, 64'h1000),
            cfg_row(wsc_pkg::REG_PATTERN_MID, 64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(wsc_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
            byte_row(8'hE8, 0),
            byte_row(8'h0F, 0),
            byte_row(8'h00, 0),
            byte_row(8'h00, 0),
            byte_row(8'h00, 0),
            hit_row(8'h80, 1, 0, 64'hFFFF_FFFF_8000_1006, 1),
            // displacement runs past the image end
            byte_row(8'hE8, 0),
            byte_row(8'h0F, 0),
            none_row(8'h11, 1),
            cfg_row(wsc_pkg::REG_MODE, 64'(wsc_pkg::MODE_RELATIVE)),
            cfg_row(wsc_pkg::REG_LENGTH, 64'd1),
            cfg_row(wsc_pkg::REG_PATTERN_LOW, 64'h8D),
            cfg_row(wsc_pkg::REG_OFFSET, 64'd1),
            byte_row(8'h8D, 0),
            byte_row(8'h10, 0),
            byte_row(8'h00, 0),
            byte_row(8'h00, 0),
            byte_row(8'h00, 1),
            cfg_row(wsc_pkg::REG_MODE, 64'(wsc_pkg::MODE_JUMP)),
            cfg_row(wsc_pkg::REG_PATTERN_LOW, 64'hE9),
            cfg_row(wsc_pkg::REG_OFFSET, 64'd0),
            cfg_row(wsc_pkg::REG_BASE, 64'd0),
            byte_row(8'hE9, 0),
            byte_row(8'hFB, 0),
            byte_row(8'hFF, 0),
            byte_row(8'hFF, 1),
            // span wider than the window never matches
            cfg_row(wsc_pkg::REG_MODE, 64'(wsc_pkg::MODE_ABSOLUTE)),
            cfg_row(wsc_pkg::REG_OFFSET, 64'd21),
            cfg_row(wsc_pkg::REG_WILDCARD, 64'hFF_FFFF),
            none_row(8'h5A, 0),
            none_row(8'hA5, 1)
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        busy = 0;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (busy)
                begin
                    wait_idle();
                    busy = 0;
                end
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                push_byte(plan[i].b, plan[i].fin, plan[i].typed, plan[i].t_has, plan[i].t_m);
                busy = 1;
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            bursty = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(wsc_pkg::REG_PATTERN_LOW, v);
            write_reg(wsc_pkg::REG_PATTERN_MID,
                      ($urandom_range(0, 5) == 0) ? '1 : {$urandom, $urandom});
            write_reg(wsc_pkg::REG_PATTERN_HIGH,
                      ($urandom_range(0, 5) == 0) ? '0 : {$urandom, $urandom});
            case ($urandom_range(0, 5))
                0:       v = '0;
                1:       v = 64'hFF_FFFF;
                2:       v = 64'($urandom_range(0, 24'hFF_FFFF));
                default: v = 64'($urandom & $urandom & $urandom & 32'hFF_FFFF);
            endcase
            write_reg(wsc_pkg::REG_WILDCARD, pad_upper(v, 24));
            case ($urandom_range(0, 7))
                0:       v = 64'd0;
                1:       v = 64'd24;
                2:       v = 64'($urandom_range(25, 31));
                default: v = 64'($urandom_range(1, 24));
            endcase
            write_reg(wsc_pkg::REG_LENGTH, pad_upper(v, 5));
            write_reg(wsc_pkg::REG_MODE, pad_upper(64'($urandom_range(0, 3)), 2));
            case ($urandom_range(0, 7))
                0:       v = 64'd0;
                1:       v = 64'd20;
                2:       v = 64'($urandom_range(21, 31));
                default: v = 64'($urandom_range(0, 20));
            endcase
            write_reg(wsc_pkg::REG_OFFSET, pad_upper(v, 5));
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(wsc_pkg::REG_BASE, v);

            pats = {pat_hi, pat_mid, pat_lo};
            span_len = eff_span();
            n_len = eff_len();
            phase_len = $urandom_range(20, 45);
            n = 0;
            while (n < phase_len)
            begin
                chunk.delete();
                if ($urandom_range(0, 2) != 0 && span_len <= MAXP)
                begin
                    // planted pattern with random wildcard and displacement bytes
                    for (int p = 0; p < span_len; p++)
                        chunk = {chunk, ((p < n_len && !wc_mask[p]) ? pats[8 * p +: 8]
                                                                   : 8'($urandom))};
                    if ($urandom_range(0, 5) == 0)
                    begin
                        k = $urandom_range(0, span_len - 1);
                        chunk[k] = chunk[k] ^ (8'd1 << $urandom_range(0, 7));
                    end
                end
                else
                    repeat ($urandom_range(1, 4)) chunk = {chunk, 8'($urandom)};
                foreach (chunk[j])
                    push_byte(chunk[j], (j == chunk.size() - 1) && ($urandom_range(0, 7) == 0),
                              0, 0, '0);
                n += chunk.size();
            end
            // some phases leave the image open across the next settings
            if ($urandom_range(0, 3) != 0)
            begin
                push_byte(8'($urandom), 1, 0, 0, '0);
                n++;
            end
            random_sent += n;
        end

        wait_idle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/wsc_pkg.sv
design/wsc_cell.sv
design/wsc_resolve.sv
design/wildcard_byte_signature_scanner.sv
sim/wildcard_byte_signature_scanner_test.sv
